// File: rtl/round_robin_task_scheduler_defines.svh
// Assertion macros shared by the scheduler's checker.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RRTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RRTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// File: rtl/rrts_pkg.sv
// Shared types and constants of the round-robin task scheduler.
package rrts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int ID_W      = 4;
  localparam int CNT_W     = 5;

  localparam logic [2:0] OP_CREATE    = 3'd0;
  localparam logic [2:0] OP_SCHEDULE  = 3'd1;
  localparam logic [2:0] OP_BLOCK     = 3'd2;
  localparam logic [2:0] OP_WAKE      = 3'd3;
  localparam logic [2:0] OP_TERMINATE = 3'd4;

  typedef enum logic [1:0] {
    TS_READY      = 2'd0,
    TS_RUNNING    = 2'd1,
    TS_BLOCKED    = 2'd2,
    TS_TERMINATED = 2'd3
  } task_st_t;

  // One access to the task table: one write and one read per cycle.
  typedef struct packed {
    logic            we;
    logic [ID_W-1:0] waddr;
    task_st_t        wdata;
    logic [ID_W-1:0] raddr;
  } mem_req_t;

endpackage

// File: rtl/rrts_task_ram.sv
// Task state table: synchronous memory with slot 0 reading as running until written.
module rrts_task_ram (
  input  logic              clk,
  input  logic              rst_n,
  input  rrts_pkg::mem_req_t req,
  output rrts_pkg::task_st_t rd_data
);
  import rrts_pkg::*;

  task_st_t mem [MAX_TASKS];
  task_st_t rd_raw_r;
  logic     rd_ovr_r;
  logic     s0_wr_r;

  // Storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_raw_r <= mem[req.raddr];
  end

  // Slot 0 holds running after reset until its first write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_wr_r  <= 1'b0;
      rd_ovr_r <= 1'b0;
    end else begin
      s0_wr_r  <= s0_wr_r | (req.we && (req.waddr == '0));
      rd_ovr_r <= !s0_wr_r && (req.raddr == '0);
    end
  end

  assign rd_data = rd_ovr_r ? TS_RUNNING : rd_raw_r;

endmodule

// File: rtl/round_robin_task_scheduler.sv
// Top level of the round-robin task scheduler: sequencer around the task table.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_ready    in_operation, in_wake_task
//  out_     output     out_valid / out_ready  out_current_task, out_switched,
//                                             out_new_task, out_table_full, out_halted
//
// Create, wake and ignored items pass to the done state without a table scan.
// Schedule, block and terminate scan the table one entry a cycle through the
// memory read port, stopping at the first ready task.
// Reset is synchronous; only task 0 exists and runs; no clearing pass is needed.
// A waiting result does not block the next input transfer; a second finished
// result waits in the sequencer until the output register frees.
module round_robin_task_scheduler (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_operation,
  input  logic [rrts_pkg::ID_W-1:0] in_wake_task,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rrts_pkg::ID_W-1:0] out_current_task,
  output logic                      out_switched,
  output logic [rrts_pkg::ID_W-1:0] out_new_task,
  output logic                      out_table_full,
  output logic                      out_halted
);
  import rrts_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RDCUR = 6'b000010,
    S_SCAN  = 6'b000100,
    S_WROLD = 6'b001000,
    S_WAKE  = 6'b010000,
    S_DONE  = 6'b100000
  } fsm_t;

  fsm_t             state_r,    state_nxt;
  logic [ID_W-1:0]  running_r,  running_nxt;
  logic [CNT_W-1:0] count_r,    count_nxt;
  logic             halt_r,     halt_nxt;
  logic             term_r,     term_nxt;
  task_st_t         cur_st_r,   cur_st_nxt;
  logic [ID_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0] left_r,     left_nxt;
  logic [ID_W-1:0]  found_r,    found_nxt;
  logic [ID_W-1:0]  wake_id_r,  wake_id_nxt;
  logic             res_sw_r,   res_sw_nxt;
  logic [ID_W-1:0]  res_new_r,  res_new_nxt;
  logic             res_full_r, res_full_nxt;

  logic             out_valid_r;
  logic [ID_W-1:0]  out_cur_r;
  logic             out_sw_r;
  logic [ID_W-1:0]  out_new_r;
  logic             out_full_r;
  logic             out_halt_r;

  mem_req_t         req;
  task_st_t         rd_data;
  logic             scan_start;
  logic             out_load;
  logic [ID_W-1:0]  next_idx;

  // Downward step through created ids, wrapping from 0 to the highest one
  function automatic logic [ID_W-1:0] wrap_dec(input logic [ID_W-1:0] idx,
                                               input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] cm1;
    cm1 = cnt - CNT_W'(1);
    return (idx == '0) ? cm1[ID_W-1:0] : idx - ID_W'(1);
  endfunction

  rrts_task_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  assign in_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    running_nxt  = running_r;
    count_nxt    = count_r;
    halt_nxt     = halt_r;
    term_nxt     = term_r;
    cur_st_nxt   = cur_st_r;
    scan_idx_nxt = scan_idx_r;
    left_nxt     = left_r;
    found_nxt    = found_r;
    wake_id_nxt  = wake_id_r;
    res_sw_nxt   = res_sw_r;
    res_new_nxt  = res_new_r;
    res_full_nxt = res_full_r;
    req.we       = 1'b0;
    req.waddr    = running_r;
    req.wdata    = TS_READY;
    req.raddr    = running_r;
    scan_start   = 1'b0;
    next_idx     = wrap_dec(running_r, count_r);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          wake_id_nxt  = in_wake_task;
          res_sw_nxt   = 1'b0;
          res_new_nxt  = '0;
          res_full_nxt = 1'b0;
          if (halt_r) begin
            state_nxt = S_DONE;
          end else begin
            case (in_operation)
              OP_CREATE: begin
                if (count_r >= CNT_W'(MAX_TASKS)) begin
                  res_full_nxt = 1'b1;
                end else begin
                  req.we      = 1'b1;
                  req.waddr   = count_r[ID_W-1:0];
                  req.wdata   = TS_READY;
                  count_nxt   = count_r + CNT_W'(1);
                  res_new_nxt = count_r[ID_W-1:0];
                end
                state_nxt = S_DONE;
              end
              OP_SCHEDULE: begin
                req.raddr = running_r;
                state_nxt = S_RDCUR;
              end
              OP_BLOCK: begin
                req.we     = 1'b1;
                req.waddr  = running_r;
                req.wdata  = TS_BLOCKED;
                cur_st_nxt = TS_BLOCKED;
                term_nxt   = 1'b0;
                scan_start = 1'b1;
              end
              OP_WAKE: begin
                if ({1'b0, in_wake_task} < count_r) begin
                  req.raddr = in_wake_task;
                  state_nxt = S_WAKE;
                end else begin
                  state_nxt = S_DONE;
                end
              end
              OP_TERMINATE: begin
                req.we     = 1'b1;
                req.waddr  = running_r;
                req.wdata  = TS_TERMINATED;
                cur_st_nxt = TS_TERMINATED;
                term_nxt   = 1'b1;
                scan_start = 1'b1;
              end
              default: begin
                state_nxt = S_DONE;
              end
            endcase
          end
        end
      end

      S_RDCUR: begin
        cur_st_nxt = rd_data;
        term_nxt   = 1'b0;
        scan_start = 1'b1;
      end

      // rd_data is the state of scan_idx_r, read last cycle
      S_SCAN: begin
        if (rd_data == TS_READY) begin
          req.we     = 1'b1;
          req.waddr  = scan_idx_r;
          req.wdata  = TS_RUNNING;
          res_sw_nxt = 1'b1;
          if (cur_st_r == TS_RUNNING) begin
            found_nxt = scan_idx_r;
            state_nxt = S_WROLD;
          end else begin
            running_nxt = scan_idx_r;
            state_nxt   = S_DONE;
          end
        end else if (left_r != '0) begin
          next_idx     = wrap_dec(scan_idx_r, count_r);
          req.raddr    = next_idx;
          scan_idx_nxt = next_idx;
          left_nxt     = left_r - CNT_W'(1);
        end else begin
          if (term_r) begin
            halt_nxt = 1'b1;
          end
          state_nxt = S_DONE;
        end
      end

      // Old task goes back to ready
      S_WROLD: begin
        req.we      = 1'b1;
        req.waddr   = running_r;
        req.wdata   = TS_READY;
        running_nxt = found_r;
        state_nxt   = S_DONE;
      end

      S_WAKE: begin
        if (rd_data == TS_BLOCKED) begin
          req.we    = 1'b1;
          req.waddr = wake_id_r;
          req.wdata = TS_READY;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Start of a scan: first read issued now, remaining ones counted down
    if (scan_start) begin
      if (count_r <= CNT_W'(1)) begin
        if (term_nxt) begin
          halt_nxt = 1'b1;
        end
        state_nxt = S_DONE;
      end else begin
        req.raddr    = next_idx;
        scan_idx_nxt = next_idx;
        left_nxt     = count_r - CNT_W'(2);
        state_nxt    = S_SCAN;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      running_r <= '0;
      count_r   <= CNT_W'(1);
      halt_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      running_r <= running_nxt;
      count_r   <= count_nxt;
      halt_r    <= halt_nxt;
    end
  end

  // Working registers of one item
  always_ff @(posedge clk) begin
    term_r     <= term_nxt;
    cur_st_r   <= cur_st_nxt;
    scan_idx_r <= scan_idx_nxt;
    left_r     <= left_nxt;
    found_r    <= found_nxt;
    wake_id_r  <= wake_id_nxt;
    res_sw_r   <= res_sw_nxt;
    res_new_r  <= res_new_nxt;
    res_full_r <= res_full_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cur_r  <= running_r;
      out_sw_r   <= res_sw_r;
      out_new_r  <= res_new_r;
      out_full_r <= res_full_r;
      out_halt_r <= halt_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_current_task = out_cur_r;
  assign out_switched     = out_sw_r;
  assign out_new_task     = out_new_r;
  assign out_table_full   = out_full_r;
  assign out_halted       = out_halt_r;

endmodule

// File: rtl/rrts_checker.sv
// Port-level checks of the scheduler and their binding to the top level.
`include "round_robin_task_scheduler_defines.svh"

module rrts_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [rrts_pkg::ID_W-1:0] out_current_task,
  input logic                      out_switched,
  input logic [rrts_pkg::ID_W-1:0] out_new_task,
  input logic                      out_table_full,
  input logic                      out_halted
);
  import rrts_pkg::*;

  // A stalled result stays offered
  `RRTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // A halted result reports nothing else
  `RRTS_ASSERT_NOW(a_halt_quiet, out_valid && out_halted,
                   !out_switched && (out_new_task == '0) && !out_table_full)

  // A failed create assigns no id and causes no switch
  `RRTS_ASSERT_NOW(a_full_quiet, out_valid && out_table_full,
                   (out_new_task == '0) && !out_switched)

  // A successful create never switches
  `RRTS_ASSERT_NOW(a_create_no_sw, out_valid && (out_new_task != '0),
                   !out_switched && !out_halted)

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (.*);
